/* hw/rtl/ray_cylinder_intersect_assert.svh */
// ---------------------------------------------------------------------------
// ray_cylinder_intersect_assert - assertion macros
// Assertion macros for the ray / cylinder intersection block.
// Each macro expects clk and rst_n in scope at the point of use.
// ---------------------------------------------------------------------------
`ifndef RAY_CYLINDER_INTERSECT_ASSERT_SVH
`define RAY_CYLINDER_INTERSECT_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define RCI_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ray_cylinder_intersect: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define RCI_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ray_cylinder_intersect: next-cycle check failed");

`endif

/* hw/rtl/rci_pkg.sv */
// ---------------------------------------------------------------------------
// rci_pkg
// Shared types and constants of the ray / cylinder intersection block.
// ---------------------------------------------------------------------------
package rci_pkg;

    // Fixed internal widths of the quadratic and discriminant path
    localparam int Q_WIDTH    = 63;
    localparam int AMAG_WIDTH = 62;
    localparam int DMAG_WIDTH = 127;
    localparam int ROOT_WIDTH = 64;
    localparam int DISC_WIDTH = 64;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // Configuration register indexes
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_IW-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_IW-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [CFG_IW-1:0] REG_AXIS_X   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_AXIS_Y   = 3'd4;
    localparam logic [CFG_IW-1:0] REG_AXIS_Z   = 3'd5;
    localparam logic [CFG_IW-1:0] REG_DIAMETER = 3'd6;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_MISS     = 2'd1,
        ST_PARALLEL = 2'd2
    } status_t;

    // One classified ray, handed from front to back
    typedef struct packed {
        status_t                       status;
        logic [DMAG_WIDTH-1:0]         dmag;
        logic signed [Q_WIDTH-1:0]     negb;
        logic [AMAG_WIDTH-1:0]         a;
        logic signed [DISC_WIDTH-1:0]  disc;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* hw/rtl/rci_front.sv */
// ---------------------------------------------------------------------------
// rci_front
// Accepts rays, removes the axial parts, forms a, b, c and the discriminant
// and classifies each ray as hit, miss or parallel.
// ---------------------------------------------------------------------------
module rci_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [W-1:0]         origin [3],
    input  logic signed [W-1:0]         dir    [3],
    input  logic signed [W-1:0]         center [3],
    input  logic signed [F+1:0]         axis   [3],
    input  logic [W-2:0]                diameter,
    input  logic                        q_full,
    output logic                        push,
    output rci_pkg::entry_t             entry
);

    localparam int AXW = F + 2;
    localparam int PCW = W + AXW;
    localparam int PQW = 2 * W;
    localparam int DW  = W - 1;
    localparam int PRW = 2 * DW;
    localparam int QW  = rci_pkg::Q_WIDTH;
    localparam int AMW = rci_pkg::AMAG_WIDTH;
    localparam int DMW = rci_pkg::DMAG_WIDTH;
    localparam int HW  = AMW / 2;
    localparam int NS  = 12;

    localparam logic signed [W-1:0]  CMAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  CMIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [63:0]   QMAX64 = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0]   QMIN64 = -QMAX64;
    localparam logic [63:0]          QMAXU  = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [QW-1:0] QMAXQ  = QW'(QMAX64);
    localparam logic signed [63:0]   DMAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0]   DMIN64 = 64'sh8000_0000_0000_0000;

    // Round a coordinate product to nearest, ties away from zero, saturate
    function automatic logic signed [W-1:0] rnd_c(input logic signed [PCW-1:0] p);
        logic [PCW:0] mag;
        logic [PCW:0] r;
        logic [PCW:0] hiw;
        logic [PCW:0] low;
        logic [W-1:0] rv;
        mag = p[PCW-1] ? (PCW+1)'(0) - {p[PCW-1], p} : {p[PCW-1], p};
        r   = (mag + ((PCW+1)'(1) << (F-1))) >> F;
        rv  = r[W-1:0];
        hiw = (PCW+1)'({(W-1){1'b1}});
        low = (PCW+1)'(1) << (W-1);
        if (!p[PCW-1])
            rnd_c = (r > hiw) ? CMAX : $signed(rv);
        else
            rnd_c = (r > low) ? CMIN : $signed(W'(0) - rv);
    endfunction

    // Round a squared-scale product into the quadratic range
    function automatic logic signed [QW-1:0] rnd_q(input logic signed [PQW-1:0] p);
        logic [PQW:0]  mag;
        logic [PQW:0]  r;
        logic [QW-1:0] rv;
        mag = p[PQW-1] ? (PQW+1)'(0) - {p[PQW-1], p} : {p[PQW-1], p};
        r   = (mag + ((PQW+1)'(1) << (F-1))) >> F;
        rv  = QW'(r);
        if (r > QMAXU)
            rnd_q = p[PQW-1] ? -QMAXQ : QMAXQ;
        else
            rnd_q = p[PQW-1] ? $signed(QW'(0) - rv) : $signed(rv);
    endfunction

    // Squared radius: diameter squared over four, rounded once
    function automatic logic signed [QW-1:0] rnd_r(input logic [PRW-1:0] p);
        logic [PRW:0] r;
        r = ((PRW+1)'(p) + ((PRW+1)'(1) << (F+1))) >> (F+2);
        rnd_r = (r > QMAXU) ? QMAXQ : $signed(QW'(r));
    endfunction

    function automatic logic signed [W-1:0] add_c(input logic signed [W-1:0] x,
                                                  input logic signed [W-1:0] y);
        logic signed [W:0] s;
        s = (W+1)'(x) + (W+1)'(y);
        if (s[W] != s[W-1])
            add_c = s[W] ? CMIN : CMAX;
        else
            add_c = s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sub_c(input logic signed [W-1:0] x,
                                                  input logic signed [W-1:0] y);
        logic signed [W:0] s;
        s = (W+1)'(x) - (W+1)'(y);
        if (s[W] != s[W-1])
            sub_c = s[W] ? CMIN : CMAX;
        else
            sub_c = s[W-1:0];
    endfunction

    function automatic logic signed [QW-1:0] add_q(input logic signed [QW-1:0] x,
                                                   input logic signed [QW-1:0] y);
        logic signed [63:0] s;
        s = 64'(x) + 64'(y);
        if (s > QMAX64)
            add_q = QMAXQ;
        else if (s < QMIN64)
            add_q = -QMAXQ;
        else
            add_q = QW'(s);
    endfunction

    function automatic logic signed [QW-1:0] sub_q(input logic signed [QW-1:0] x,
                                                   input logic signed [QW-1:0] y);
        logic signed [63:0] s;
        s = 64'(x) - 64'(y);
        if (s > QMAX64)
            sub_q = QMAXQ;
        else if (s < QMIN64)
            sub_q = -QMAXQ;
        else
            sub_q = QW'(s);
    endfunction

    logic                   vld_reg [NS];
    logic                   en;

    logic signed [W-1:0]    dir0_reg [3];
    logic signed [W-1:0]    off0_reg [3];
    logic signed [W-1:0]    dir1_reg [3];
    logic signed [W-1:0]    off1_reg [3];
    logic signed [W-1:0]    tdd_reg  [3];
    logic signed [W-1:0]    tdo_reg  [3];
    logic signed [W-1:0]    dir2_reg [3];
    logic signed [W-1:0]    off2_reg [3];
    logic signed [W-1:0]    ald_reg;
    logic signed [W-1:0]    alo_reg;
    logic signed [W-1:0]    dir3_reg [3];
    logic signed [W-1:0]    off3_reg [3];
    logic signed [W-1:0]    pdt_reg  [3];
    logic signed [W-1:0]    pot_reg  [3];
    logic signed [W-1:0]    pd_reg   [3];
    logic signed [W-1:0]    po_reg   [3];
    logic signed [QW-1:0]   qa_reg   [3];
    logic signed [QW-1:0]   qb_reg   [3];
    logic signed [QW-1:0]   qc_reg   [3];
    logic signed [QW-1:0]   r2_reg;
    logic signed [QW-1:0]   a6_reg;
    logic signed [QW-1:0]   b6_reg;
    logic signed [QW-1:0]   c6_reg;
    logic signed [QW-1:0]   r26_reg;
    logic [AMW-1:0]         a7_reg;
    logic signed [QW-1:0]   b7_reg;
    logic [AMW-1:0]         bmag7_reg;
    logic [AMW-1:0]         cmag7_reg;
    logic                   cpos7_reg;
    logic [AMW-1:0]         a8_reg;
    logic signed [QW-1:0]   b8_reg;
    logic                   cpos8_reg;
    logic [AMW-1:0]         pbhh_reg;
    logic [AMW-1:0]         pbhl_reg;
    logic [AMW-1:0]         pbll_reg;
    logic [AMW-1:0]         pahh_reg;
    logic [AMW-1:0]         pahl_reg;
    logic [AMW-1:0]         palh_reg;
    logic [AMW-1:0]         pall_reg;
    logic [AMW-1:0]         a9_reg;
    logic signed [QW-1:0]   b9_reg;
    logic                   cpos9_reg;
    logic [123:0]           b2_reg;
    logic [123:0]           ac_reg;
    logic [AMW-1:0]         a10_reg;
    logic signed [QW-1:0]   b10_reg;
    logic [DMW-1:0]         dmag_reg;
    logic                   dneg_reg;
    rci_pkg::entry_t        entry_reg;

    logic signed [PCW-1:0]  pdd  [3];
    logic signed [PCW-1:0]  pdo  [3];
    logic signed [PCW-1:0]  pad  [3];
    logic signed [PCW-1:0]  pao  [3];
    logic signed [PQW-1:0]  pqa  [3];
    logic signed [PQW-1:0]  pqb  [3];
    logic signed [PQW-1:0]  pqc  [3];
    logic [PRW-1:0]         prr;
    logic signed [QW-1:0]   bs;
    logic signed [QW-1:0]   cs;
    logic [125:0]           ac4;
    logic [DMW-1:0]         dmag_next;
    logic                   dneg_next;
    logic signed [63:0]     disc_next;
    rci_pkg::status_t       status_next;

    // Stall the whole front only when its last stage cannot drain
    assign en       = !(vld_reg[NS-1] && q_full);
    assign in_ready = en;
    assign push     = en && vld_reg[NS-1];
    assign entry    = entry_reg;

    // Products of the projection and quadratic stages
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pdd[i] = PCW'(dir0_reg[i]) * PCW'(axis[i]);
            pdo[i] = PCW'(off0_reg[i]) * PCW'(axis[i]);
            pad[i] = PCW'(axis[i]) * PCW'(ald_reg);
            pao[i] = PCW'(axis[i]) * PCW'(alo_reg);
            pqa[i] = PQW'(pd_reg[i]) * PQW'(pd_reg[i]);
            pqb[i] = PQW'(pd_reg[i]) * PQW'(po_reg[i]);
            pqc[i] = PQW'(po_reg[i]) * PQW'(po_reg[i]);
        end
        prr = PRW'(diameter) * PRW'(diameter);
    end

    // Final b and c with their magnitudes
    assign bs = add_q(b6_reg, b6_reg);
    assign cs = sub_q(c6_reg, r26_reg);

    // Discriminant from b squared and 4ac
    assign ac4 = {ac_reg, 2'b00};
    always_comb
    begin
        if (!cpos9_reg)
        begin
            dmag_next = DMW'(b2_reg) + DMW'(ac4);
            dneg_next = 1'b0;
        end
        else if (126'(b2_reg) >= ac4)
        begin
            dmag_next = DMW'(126'(b2_reg) - ac4);
            dneg_next = 1'b0;
        end
        else
        begin
            dmag_next = DMW'(ac4 - 126'(b2_reg));
            dneg_next = 1'b1;
        end
    end

    // Classify and saturate the reported discriminant
    always_comb
    begin
        if (!dneg_reg)
            disc_next = (dmag_reg > DMW'(DMAX64)) ? DMAX64 : $signed(dmag_reg[63:0]);
        else
            disc_next = (dmag_reg > (DMW'(1) << 63)) ? DMIN64 :
                        $signed(64'(0) - dmag_reg[63:0]);
        if (a10_reg == '0)
            status_next = rci_pkg::ST_PARALLEL;
        else if (dneg_reg)
            status_next = rci_pkg::ST_MISS;
        else
            status_next = rci_pkg::ST_HIT;
    end

    // Advance the valid marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dir0_reg[i] <= dir[i];
                off0_reg[i] <= sub_c(origin[i], center[i]);
                dir1_reg[i] <= dir0_reg[i];
                off1_reg[i] <= off0_reg[i];
                tdd_reg[i]  <= rnd_c(pdd[i]);
                tdo_reg[i]  <= rnd_c(pdo[i]);
                dir2_reg[i] <= dir1_reg[i];
                off2_reg[i] <= off1_reg[i];
                dir3_reg[i] <= dir2_reg[i];
                off3_reg[i] <= off2_reg[i];
                pdt_reg[i]  <= rnd_c(pad[i]);
                pot_reg[i]  <= rnd_c(pao[i]);
                pd_reg[i]   <= sub_c(dir3_reg[i], pdt_reg[i]);
                po_reg[i]   <= sub_c(off3_reg[i], pot_reg[i]);
                qa_reg[i]   <= rnd_q(pqa[i]);
                qb_reg[i]   <= rnd_q(pqb[i]);
                qc_reg[i]   <= rnd_q(pqc[i]);
            end
            ald_reg   <= add_c(add_c(tdd_reg[0], tdd_reg[1]), tdd_reg[2]);
            alo_reg   <= add_c(add_c(tdo_reg[0], tdo_reg[1]), tdo_reg[2]);
            r2_reg    <= rnd_r(prr);
            a6_reg    <= add_q(add_q(qa_reg[0], qa_reg[1]), qa_reg[2]);
            b6_reg    <= add_q(add_q(qb_reg[0], qb_reg[1]), qb_reg[2]);
            c6_reg    <= add_q(add_q(qc_reg[0], qc_reg[1]), qc_reg[2]);
            r26_reg   <= r2_reg;
            a7_reg    <= AMW'(a6_reg);
            b7_reg    <= bs;
            bmag7_reg <= (bs < 0) ? AMW'(-bs) : AMW'(bs);
            cmag7_reg <= (cs < 0) ? AMW'(-cs) : AMW'(cs);
            cpos7_reg <= (cs > 0);
            // Split the 62-bit magnitudes into 31-bit halves
            pbhh_reg  <= AMW'(bmag7_reg[AMW-1:HW]) * AMW'(bmag7_reg[AMW-1:HW]);
            pbhl_reg  <= AMW'(bmag7_reg[AMW-1:HW]) * AMW'(bmag7_reg[HW-1:0]);
            pbll_reg  <= AMW'(bmag7_reg[HW-1:0]) * AMW'(bmag7_reg[HW-1:0]);
            pahh_reg  <= AMW'(a7_reg[AMW-1:HW]) * AMW'(cmag7_reg[AMW-1:HW]);
            pahl_reg  <= AMW'(a7_reg[AMW-1:HW]) * AMW'(cmag7_reg[HW-1:0]);
            palh_reg  <= AMW'(a7_reg[HW-1:0]) * AMW'(cmag7_reg[AMW-1:HW]);
            pall_reg  <= AMW'(a7_reg[HW-1:0]) * AMW'(cmag7_reg[HW-1:0]);
            a8_reg    <= a7_reg;
            b8_reg    <= b7_reg;
            cpos8_reg <= cpos7_reg;
            // Recombine the partial products
            b2_reg    <= (124'(pbhh_reg) << AMW) + (124'(pbhl_reg) << (HW+1))
                         + 124'(pbll_reg);
            ac_reg    <= (124'(pahh_reg) << AMW)
                         + ((124'(pahl_reg) + 124'(palh_reg)) << HW) + 124'(pall_reg);
            a9_reg    <= a8_reg;
            b9_reg    <= b8_reg;
            cpos9_reg <= cpos8_reg;
            dmag_reg  <= dmag_next;
            dneg_reg  <= dneg_next;
            a10_reg   <= a9_reg;
            b10_reg   <= b9_reg;
            entry_reg.status <= status_next;
            entry_reg.dmag   <= dmag_reg;
            entry_reg.negb   <= -b10_reg;
            entry_reg.a      <= a10_reg;
            entry_reg.disc   <= disc_next;
        end
    end

endmodule

/* hw/rtl/rci_queue.sv */
// ---------------------------------------------------------------------------
// rci_queue
// Short first-in first-out queue that decouples front and back.
// ---------------------------------------------------------------------------
module rci_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rci_pkg::entry_t       wdata,
    input  logic                  pop,
    output rci_pkg::entry_t       rdata,
    output rci_pkg::q_status_t    stat
);

    localparam int AW = rci_pkg::Q_AW;

    rci_pkg::entry_t    mem [rci_pkg::Q_DEPTH];
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic [AW:0]        cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign stat.full  = (cnt_reg == (AW+1)'(rci_pkg::Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rdata      = mem[rd_ptr_reg];

    // Store a beat
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

    // Move the pointers and the fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + (AW+1)'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - (AW+1)'(1);
        end
    end

endmodule

/* hw/rtl/rci_back.sv */
// ---------------------------------------------------------------------------
// rci_back
// Pipelined square root and two pipelined dividers that turn a classified
// ray into its two roots, followed by the output register.
// ---------------------------------------------------------------------------
module rci_back #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rci_pkg::entry_t             q_entry,
    input  rci_pkg::q_status_t          q_stat,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output rci_pkg::status_t            out_status,
    output logic signed [W-1:0]         out_near,
    output logic signed [W-1:0]         out_far,
    output logic signed [63:0]          out_disc
);

    localparam int QW  = rci_pkg::Q_WIDTH;
    localparam int AMW = rci_pkg::AMAG_WIDTH;
    localparam int DMW = rci_pkg::DMAG_WIDTH;
    localparam int RTW = rci_pkg::ROOT_WIDTH;
    localparam int XW  = DMW + 1;
    localparam int SRW = RTW + 1;
    localparam int CW  = RTW + 3;
    localparam int MW  = RTW + 1;
    localparam int NW  = MW + F;
    localparam int DNW = AMW + 1;

    localparam logic signed [W-1:0] CMAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN  = {1'b1, {(W-1){1'b0}}};
    localparam logic [NW:0]         CMAXW = (NW+1)'({(W-1){1'b1}});
    localparam logic [NW:0]         CMINW = (NW+1)'(1) << (W-1);

    typedef struct packed {
        rci_pkg::status_t           status;
        logic signed [QW-1:0]       negb;
        logic [AMW-1:0]             a;
        logic signed [63:0]         disc;
    } sq_pl_t;

    typedef struct packed {
        rci_pkg::status_t           status;
        logic                       neg_near;
        logic                       neg_far;
        logic [AMW-1:0]             a;
        logic signed [63:0]         disc;
    } dv_pl_t;

    logic                   en;

    logic                   sv_reg    [RTW+1];
    logic [XW-1:0]          sx_reg    [RTW];
    logic [SRW-1:0]         srem_reg  [RTW];
    logic [RTW-1:0]         sroot_reg [RTW+1];
    sq_pl_t                 spl_reg   [RTW+1];

    logic                   dv_reg    [NW+1];
    logic [NW-1:0]          dnq_reg   [2][NW+1];
    logic [DNW-1:0]         drem_reg  [2][NW+1];
    dv_pl_t                 dpl_reg   [NW+1];

    logic                   ov_reg;
    rci_pkg::status_t       ost_reg;
    logic signed [W-1:0]    ot_reg    [2];
    logic signed [63:0]     odisc_reg;

    logic signed [MW:0]     nb;
    logic signed [MW:0]     sroot_s;
    logic signed [MW:0]     snear;
    logic signed [MW:0]     sfar;
    logic signed [W-1:0]    t_sat     [2];
    logic                   lane_neg  [2];

    // Stall everything behind a result that waits to be taken
    assign en    = !ov_reg || out_ready;
    assign q_pop = en && !q_stat.empty;

    // Load a beat from the queue into the root stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg[0] <= 1'b0;
        else if (en)
            sv_reg[0] <= !q_stat.empty;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg[0]         <= {1'b0, q_entry.dmag};
            srem_reg[0]       <= '0;
            sroot_reg[0]      <= '0;
            spl_reg[0].status <= q_entry.status;
            spl_reg[0].negb   <= q_entry.negb;
            spl_reg[0].a      <= q_entry.a;
            spl_reg[0].disc   <= q_entry.disc;
        end
    end

    // Square root, one result bit per stage
    for (genvar k = 0; k < RTW; k++)
    begin : g_sqrt
        logic [CW-1:0] cur;
        logic [CW-1:0] trial;
        logic          ge;

        assign cur   = {srem_reg[k], sx_reg[k][XW-1:XW-2]};
        assign trial = CW'({sroot_reg[k], 2'b01});
        assign ge    = (cur >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[k+1] <= 1'b0;
            else if (en)
                sv_reg[k+1] <= sv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sroot_reg[k+1] <= {sroot_reg[k][RTW-2:0], ge};
                spl_reg[k+1]   <= spl_reg[k];
            end
        end

        if (k < RTW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    srem_reg[k+1] <= SRW'(ge ? cur - trial : cur);
                    sx_reg[k+1]   <= {sx_reg[k][XW-3:0], 2'b00};
                end
            end
        end
    end

    // Form -b minus and plus the root as sign and magnitude
    assign nb      = (MW+1)'(spl_reg[RTW].negb);
    assign sroot_s = $signed({2'b00, sroot_reg[RTW]});
    assign snear   = nb - sroot_s;
    assign sfar    = nb + sroot_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else if (en)
            dv_reg[0] <= sv_reg[RTW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dnq_reg[0][0]       <= {MW'(snear < 0 ? -snear : snear), {F{1'b0}}};
            dnq_reg[1][0]       <= {MW'(sfar < 0 ? -sfar : sfar), {F{1'b0}}};
            drem_reg[0][0]      <= '0;
            drem_reg[1][0]      <= '0;
            dpl_reg[0].status   <= spl_reg[RTW].status;
            dpl_reg[0].neg_near <= (snear < 0);
            dpl_reg[0].neg_far  <= (sfar < 0);
            dpl_reg[0].a        <= spl_reg[RTW].a;
            dpl_reg[0].disc     <= spl_reg[RTW].disc;
        end
    end

    // Long division by 2a, one quotient bit per stage, two lanes
    for (genvar j = 0; j < NW; j++)
    begin : g_div
        logic [DNW-1:0] den;

        assign den = {dpl_reg[j].a, 1'b0};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[j+1] <= 1'b0;
            else if (en)
                dv_reg[j+1] <= dv_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                dpl_reg[j+1] <= dpl_reg[j];
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [DNW:0] cur;
            logic         ge;

            assign cur = {drem_reg[l][j], dnq_reg[l][j][NW-1]};
            assign ge  = (cur >= (DNW+1)'(den));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    drem_reg[l][j+1] <= DNW'(ge ? cur - (DNW+1)'(den) : cur);
                    dnq_reg[l][j+1]  <= {dnq_reg[l][j][NW-2:0], ge};
                end
            end
        end
    end

    // Round to nearest and saturate each root
    assign lane_neg[0] = dpl_reg[NW].neg_near;
    assign lane_neg[1] = dpl_reg[NW].neg_far;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            logic [NW:0] qr;
            qr = (NW+1)'(dnq_reg[l][NW])
                 + (NW+1)'(({drem_reg[l][NW], 1'b0}) >= (DNW+1)'({dpl_reg[NW].a, 1'b0}));
            if (!lane_neg[l])
                t_sat[l] = (qr > CMAXW) ? CMAX : $signed(W'(qr));
            else
                t_sat[l] = (qr > CMINW) ? CMIN : $signed(W'(0) - W'(qr));
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= dv_reg[NW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ost_reg   <= dpl_reg[NW].status;
            odisc_reg <= dpl_reg[NW].disc;
            for (int l = 0; l < 2; l++)
                ot_reg[l] <= (dpl_reg[NW].status == rci_pkg::ST_HIT) ? t_sat[l] : CMAX;
        end
    end

    assign out_valid  = ov_reg;
    assign out_status = ost_reg;
    assign out_near   = ot_reg[0];
    assign out_far    = ot_reg[1];
    assign out_disc   = odisc_reg;

endmodule

/* hw/rtl/ray_cylinder_intersect.sv */
// ---------------------------------------------------------------------------
// ray_cylinder_intersect - ray against infinite cylinder, both roots
// Throughput: one ray per cycle while m_tready does not stall the result stream; the root and divider pipelines set it.
// Reset: config to centre 0, axis (0,1,0), diameter 1.0; pipelines emptied.
// ---------------------------------------------------------------------------
`include "ray_cylinder_intersect_assert.svh"

module ray_cylinder_intersect #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    // Write port for configuration
    input  logic                                          cfg_we,
    input  logic [rci_pkg::CFG_IW-1:0]                    cfg_index,
    input  logic [((COORD_WIDTH > FRAC_BITS + 2) ? COORD_WIDTH : FRAC_BITS + 2)-1:0] cfg_data,
    // Ray stream
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]            s_tdata,
    // Result stream
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // t_near, t_far, discriminant
    output logic [((2*COORD_WIDTH+64+7)/8)*8-1:0]         m_tdata,
    // hit_status
    output logic [1:0]                                    m_tuser
);

    localparam int W  = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int OW = ((2*COORD_WIDTH+64+7)/8)*8;

    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};

    logic signed [W-1:0]    center_reg [3];
    logic signed [F+1:0]    axis_reg   [3];
    logic [W-2:0]           diameter_reg;

    logic signed [W-1:0]    origin [3];
    logic signed [W-1:0]    dir    [3];

    logic                   q_push;
    logic                   q_pop;
    rci_pkg::entry_t        q_wdata;
    rci_pkg::entry_t        q_rdata;
    rci_pkg::q_status_t     q_stat;

    rci_pkg::status_t       res_status;
    logic signed [W-1:0]    res_near;
    logic signed [W-1:0]    res_far;
    logic signed [63:0]     res_disc;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            axis_reg[0]   <= '0;
            axis_reg[1]   <= (F+2)'(1) << F;
            axis_reg[2]   <= '0;
            diameter_reg  <= (W-1)'(1) << F;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rci_pkg::REG_CENTER_X: center_reg[0] <= cfg_data[W-1:0];
                rci_pkg::REG_CENTER_Y: center_reg[1] <= cfg_data[W-1:0];
                rci_pkg::REG_CENTER_Z: center_reg[2] <= cfg_data[W-1:0];
                rci_pkg::REG_AXIS_X:   axis_reg[0]   <= cfg_data[F+1:0];
                rci_pkg::REG_AXIS_Y:   axis_reg[1]   <= cfg_data[F+1:0];
                rci_pkg::REG_AXIS_Z:   axis_reg[2]   <= cfg_data[F+1:0];
                rci_pkg::REG_DIAMETER: diameter_reg  <= cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    // Unpack the ray beat
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            origin[i] = s_tdata[i*W +: W];
            dir[i]    = s_tdata[(3+i)*W +: W];
        end
    end

    rci_front #(
        .W (W),
        .F (F)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .origin   (origin),
        .dir      (dir),
        .center   (center_reg),
        .axis     (axis_reg),
        .diameter (diameter_reg),
        .q_full   (q_stat.full),
        .push     (q_push),
        .entry    (q_wdata)
    );

    rci_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    rci_back #(
        .W (W),
        .F (F)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_entry    (q_rdata),
        .q_stat     (q_stat),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (res_status),
        .out_near   (res_near),
        .out_far    (res_far),
        .out_disc   (res_disc)
    );

    // Pack the result beat
    assign m_tdata = OW'({res_disc, res_far, res_near});
    assign m_tuser = res_status;

    // Front never pushes into a full queue
    `RCI_ASSERT_IMPL(a_no_overflow, q_push, !q_stat.full)
    // Roots are ordered on a hit and held at maximum otherwise
    `RCI_ASSERT_IMPL(a_root_order, m_tvalid && (res_status == rci_pkg::ST_HIT), res_near <= res_far)
    `RCI_ASSERT_IMPL(a_no_root, m_tvalid && (res_status != rci_pkg::ST_HIT), (res_near == CMAX) && (res_far == CMAX))
    // Discriminant sign agrees with the miss flag
    `RCI_ASSERT_IMPL(a_disc_sign, m_tvalid, res_disc[63] == (res_status == rci_pkg::ST_MISS))

endmodule

/* tb/sv/tb.sv */
// ---------------------------------------------------------------------------
// tb - ray against infinite cylinder, self-checking testbench
// Sends rays over the input stream and predicts each result in fixed point:
// the axial part is removed, the quadratic and its discriminant are formed,
// and both roots are worked out. Every result beat is checked field by field.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam int CW = 32;
    localparam longint CMAX = 64'sd2147483647;
    localparam longint CMIN = -64'sd2147483648;
    localparam longint QMAX = (64'sd1 <<< 62) - 64'sd1;
    localparam longint QMIN = -QMAX;
    localparam longint SMAX = 64'h7fff_ffff_ffff_ffff;
    localparam longint SMIN = 64'h8000_0000_0000_0000;
    localparam longint ONE = 64'sd65536;
    // Index with no register behind it
    localparam logic [rci_pkg::CFG_IW-1:0] REG_UNUSED = 3'd7;
    localparam int LATENCY = 145 + FB;

    typedef longint vec3_t[3];

    typedef struct {
        logic [31:0] org[3];
        logic [31:0] dir[3];
    } ray_t;

    typedef struct {
        rci_pkg::status_t status;
        logic [31:0] t_near;
        logic [31:0] t_far;
        logic [63:0] disc;
    } hit_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [rci_pkg::CFG_IW-1:0] cfg_index;
    logic [CW-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [191:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [127:0] m_tdata;
    logic [1:0] m_tuser;

    // Shadow copy of the cylinder set-up
    longint cyl_center[3];
    longint cyl_axis[3];
    longint cyl_diam;

    hit_t pending_hits[$];
    int err_count = 0;
    int burst_left = 0;
    bit hold_req = 0;

    ray_cylinder_intersect dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // -----------------------------------------------------------------------
    // Fixed-point helpers
    // -----------------------------------------------------------------------
    function automatic logic [63:0] magn(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sat_mag(logic [127:0] m, bit neg, longint lo, longint hi);
        if (!neg)
            return (m > {64'd0, 64'(hi)}) ? hi : longint'(m[63:0]);
        if (m > {64'd0, magn(lo)})
            return lo;
        return -longint'(m[63:0]);
    endfunction

    // Exact product, rounded half away from zero, then saturated
    function automatic longint mul_q(longint x, longint y, int sh, longint lo, longint hi);
        logic [127:0] m;
        m = {64'd0, magn(x)} * {64'd0, magn(y)};
        if (sh > 0)
            m = (m + (128'd1 << (sh - 1))) >> sh;
        return sat_mag(m, (x < 0) != (y < 0), lo, hi);
    endfunction

    function automatic longint dot3(vec3_t x, vec3_t y, longint lo, longint hi);
        longint s;
        s = 0;
        for (int i = 0; i < 3; i++)
            s = clampv(s + mul_q(x[i], y[i], FB, lo, hi), lo, hi);
        return s;
    endfunction

    function automatic logic [63:0] isqrt(logic [127:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int i = 63; i >= 0; i--)
        begin
            t = r | (64'd1 << i);
            if ({64'd0, t} * {64'd0, t} <= x)
                r = t;
        end
        return r;
    endfunction

    // (negb -/+ s) / 2a, rounded and saturated to the coordinate range
    function automatic longint root_of(longint negb, logic [63:0] s, bit add, longint a);
        logic [63:0] mx;
        logic [63:0] m;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        logic [127:0] rem;
        bit xneg;
        bit neg;
        mx = magn(negb);
        xneg = negb < 0;
        if (xneg == add)
        begin
            if (mx >= s)
            begin
                neg = xneg;
                m = mx - s;
            end
            else
            begin
                neg = !xneg;
                m = s - mx;
            end
        end
        else
        begin
            neg = xneg;
            m = mx + s;
        end
        num = {64'd0, m} << FB;
        den = {64'd0, 64'(a)} << 1;
        q = num / den;
        rem = num % den;
        if ((rem << 1) >= den)
            q = q + 1;
        return sat_mag(q, neg, CMIN, CMAX);
    endfunction

    // -----------------------------------------------------------------------
    // Predict the result of one ray under the current set-up
    // -----------------------------------------------------------------------
    function automatic hit_t predict_hit(ray_t r);
        vec3_t dir, off, pd, po;
        longint along_d, along_o, a, b, c;
        logic [127:0] b2, ac4, dmag;
        bit dneg;
        hit_t h;
        for (int i = 0; i < 3; i++)
        begin
            off[i] = clampv(longint'($signed(r.org[i])) - cyl_center[i], CMIN, CMAX);
            dir[i] = longint'($signed(r.dir[i]));
        end
        along_d = dot3(dir, cyl_axis, CMIN, CMAX);
        along_o = dot3(off, cyl_axis, CMIN, CMAX);
        for (int i = 0; i < 3; i++)
        begin
            pd[i] = clampv(dir[i] - mul_q(cyl_axis[i], along_d, FB, CMIN, CMAX), CMIN, CMAX);
            po[i] = clampv(off[i] - mul_q(cyl_axis[i], along_o, FB, CMIN, CMAX), CMIN, CMAX);
        end
        a = dot3(pd, pd, QMIN, QMAX);
        b = clampv(2 * dot3(pd, po, QMIN, QMAX), QMIN, QMAX);
        c = clampv(dot3(po, po, QMIN, QMAX) - mul_q(cyl_diam, cyl_diam, FB + 2, QMIN, QMAX),
                   QMIN, QMAX);

        b2 = {64'd0, magn(b)} * {64'd0, magn(b)};
        ac4 = ({64'd0, 64'(a)} * {64'd0, magn(c)}) << 2;
        if (c <= 0)
        begin
            dmag = b2 + ac4;
            dneg = 0;
        end
        else if (b2 >= ac4)
        begin
            dmag = b2 - ac4;
            dneg = 0;
        end
        else
        begin
            dmag = ac4 - b2;
            dneg = 1;
        end
        h.disc = 64'(sat_mag(dmag, dneg, SMIN, SMAX));
        h.t_near = CMAX[31:0];
        h.t_far = CMAX[31:0];
        if (a == 0)
            h.status = rci_pkg::ST_PARALLEL;
        else if (dneg)
            h.status = rci_pkg::ST_MISS;
        else
        begin
            h.status = rci_pkg::ST_HIT;
            h.t_near = 32'(root_of(-b, isqrt(dmag), 0, a));
            h.t_far = 32'(root_of(-b, isqrt(dmag), 1, a));
        end
        return h;
    endfunction

    // -----------------------------------------------------------------------
    // Clock, limit and result checking
    // -----------------------------------------------------------------------
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_hits.size() == 0)
            begin
                $error("result beat with no ray outstanding");
                err_count++;
            end
            else
            begin
                hit_t h;
                h = pending_hits.pop_front();
                if (m_tuser != h.status)
                begin
                    $error("hit_status: expected %0d, got %0d", h.status, m_tuser);
                    err_count++;
                end
                if (m_tdata[31:0] != h.t_near)
                begin
                    $error("t_near: expected %h, got %h", h.t_near, m_tdata[31:0]);
                    err_count++;
                end
                if (m_tdata[63:32] != h.t_far)
                begin
                    $error("t_far: expected %h, got %h", h.t_far, m_tdata[63:32]);
                    err_count++;
                end
                if (m_tdata[127:64] != h.disc)
                begin
                    $error("discriminant: expected %h, got %h", h.disc, m_tdata[127:64]);
                    err_count++;
                end
            end
        end
    end

    // Receiver: stall on a changing pattern, or hold off on request
    initial
    begin
        int cyc;
        int mode;
        cyc = 0;
        mode = 0;
        m_tready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                m_tready <= 0;
                repeat (600) @(posedge clk);
            end
            cyc++;
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 2);
            case (mode)
                0: m_tready <= 1;
                1: m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus tasks
    // -----------------------------------------------------------------------
    task automatic write_reg(logic [rci_pkg::CFG_IW-1:0] idx, logic [31:0] d);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
        case (idx)
            rci_pkg::REG_CENTER_X: cyl_center[0] = longint'($signed(d));
            rci_pkg::REG_CENTER_Y: cyl_center[1] = longint'($signed(d));
            rci_pkg::REG_CENTER_Z: cyl_center[2] = longint'($signed(d));
            rci_pkg::REG_AXIS_X:   cyl_axis[0] = longint'($signed(d[17:0]));
            rci_pkg::REG_AXIS_Y:   cyl_axis[1] = longint'($signed(d[17:0]));
            rci_pkg::REG_AXIS_Z:   cyl_axis[2] = longint'($signed(d[17:0]));
            rci_pkg::REG_DIAMETER: cyl_diam = longint'(d[30:0]);
            default: ;
        endcase
    endtask

    task automatic set_cylinder(longint cx, longint cy, longint cz,
                                longint ax, longint ay, longint az, longint d);
        write_reg(rci_pkg::REG_CENTER_X, 32'(cx));
        write_reg(rci_pkg::REG_CENTER_Y, 32'(cy));
        write_reg(rci_pkg::REG_CENTER_Z, 32'(cz));
        write_reg(rci_pkg::REG_AXIS_X, 32'(ax));
        write_reg(rci_pkg::REG_AXIS_Y, 32'(ay));
        write_reg(rci_pkg::REG_AXIS_Z, 32'(az));
        write_reg(rci_pkg::REG_DIAMETER, 32'(d));
    endtask

    // Offer one ray, in bursts with random gaps, and predict it on acceptance
    task automatic send_ray(ray_t r);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        s_tvalid <= 1;
        s_tdata <= {r.dir[2], r.dir[1], r.dir[0], r.org[2], r.org[1], r.org[0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_hits.push_back(predict_hit(r));
        burst_left--;
    endtask

    task automatic send_xyz(longint ox, longint oy, longint oz,
                            longint dx, longint dy, longint dz);
        ray_t r;
        r.org[0] = 32'(ox); r.org[1] = 32'(oy); r.org[2] = 32'(oz);
        r.dir[0] = 32'(dx); r.dir[1] = 32'(dy); r.dir[2] = 32'(dz);
        send_ray(r);
    endtask

    // Stop offering and wait until every result is back
    task automatic drain();
        s_tvalid <= 0;
        burst_left = 0;
        @(posedge clk);
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(int span);
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: case ($urandom_range(0, 4))
                0: return CMAX[31:0];
                1: return CMIN[31:0];
                2: return 32'd0;
                3: return 32'd1;
                default: return 32'hffff_ffff;
            endcase
            default: return 32'($urandom_range(0, 2 * span) - span);
        endcase
    endfunction

    function automatic ray_t rand_ray(int span);
        ray_t r;
        for (int i = 0; i < 3; i++)
        begin
            r.org[i] = rand_coord(span);
            r.dir[i] = rand_coord(span / 2);
        end
        // Now and then drop one direction component for near-parallel rays
        if ($urandom_range(0, 7) == 0)
            r.dir[$urandom_range(0, 2)] = 0;
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    // Reset set-up: unit cylinder along y
    task automatic test_directed();
        send_xyz(-5 * ONE, 0, 0, ONE, 0, 0);          // through the axis
        send_xyz(-5 * ONE, 0, 3 * ONE, ONE, 0, 0);    // clear miss
        send_xyz(0, 0, 0, 0, ONE, 0);                 // along the axis
        send_xyz(ONE, 2 * ONE, 0, 0, -7 * ONE, 0);    // parallel, outside
        send_xyz(-5 * ONE, 0, ONE / 2, ONE, 0, 0);    // tangent, zero discriminant
        send_xyz(0, 0, 0, 0, 0, 0);                   // no direction at all
        send_xyz(0, 0, 0, 0, 0, ONE);                 // starts inside
        send_xyz(ONE / 4, 3 * ONE, -ONE, ONE, ONE, ONE);
        send_xyz(-3 * ONE, 0, 0, 1, 0, 0);            // tiny direction, a rounds to zero
        send_xyz(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        send_xyz(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
        send_xyz(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);
        send_xyz(CMIN, 0, CMAX, ONE, 0, -ONE);
        send_xyz(CMAX, 0, 0, CMIN, 0, 0);
        send_xyz(-1, -1, -1, -1, -1, -1);
        send_xyz(0, 0, 0, CMAX, 0, CMAX);
        send_xyz(5 * ONE, 0, 0, -ONE, 0, 1);
        send_xyz(0, 0, 0, 1, 1, 1);
        drain();
    endtask

    // Register extremes, raw axis values and bits above the register width
    task automatic test_cfg_extremes();
        set_cylinder(CMAX, CMIN, CMAX, 64'h3fff_e0000, 64'h1ffff, 64'h7ff_20000, 64'h7fff_ffff);
        for (int i = 0; i < 12; i++)
            send_ray(rand_ray(16 * 65536));
        drain();
        set_cylinder(CMIN, CMAX, CMIN, -ONE, ONE, ONE, 0);
        write_reg(REG_UNUSED, 32'hdead_beef);
        for (int i = 0; i < 12; i++)
            send_ray(rand_ray(16 * 65536));
        send_xyz(0, 0, 0, ONE, 0, 0);
        drain();
        set_cylinder(0, 0, 0, 0, 0, 0, 64'hffff_ffff);
        for (int i = 0; i < 8; i++)
            send_ray(rand_ray(8 * 65536));
        drain();
    endtask

    // Random rays under a series of cylinder set-ups
    task automatic test_random();
        longint ax[3];
        for (int p = 0; p < 6; p++)
        begin
            ax[0] = 0; ax[1] = 0; ax[2] = 0;
            case ($urandom_range(0, 3))
                0: ax[$urandom_range(0, 2)] = ONE;
                1: ax[$urandom_range(0, 2)] = -ONE;
                2: begin ax[0] = 46341; ax[2] = -46341; end
                default: begin ax[0] = 37837; ax[1] = 37837; ax[2] = 37837; end
            endcase
            set_cylinder(longint'($urandom_range(0, 16 * 65536)) - 8 * ONE,
                         longint'($urandom_range(0, 16 * 65536)) - 8 * ONE,
                         longint'($urandom_range(0, 16 * 65536)) - 8 * ONE,
                         ax[0], ax[1], ax[2],
                         (p == 0) ? 64'sd1 : longint'($urandom_range(1, 12 * 65536)));
            for (int i = 0; i < 270; i++)
                send_ray(rand_ray(12 * 65536));
            drain();
        end
    endtask

    // Long receiver hold-off while rays keep coming
    task automatic test_backpressure();
        set_cylinder(0, 0, 0, 0, 0, ONE, 3 * ONE);
        hold_req = 1;
        for (int i = 0; i < 260; i++)
            send_ray(rand_ray(6 * 65536));
        drain();
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 0;
        s_tdata = '0;
        cyl_center[0] = 0; cyl_center[1] = 0; cyl_center[2] = 0;
        cyl_axis[0] = 0; cyl_axis[1] = ONE; cyl_axis[2] = 0;
        cyl_diam = ONE;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        test_directed();
        test_cfg_extremes();
        test_random();
        test_backpressure();

        repeat (LATENCY + 40) @(posedge clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/rci_pkg.sv
hw/rtl/rci_front.sv
hw/rtl/rci_queue.sv
hw/rtl/rci_back.sv
hw/rtl/ray_cylinder_intersect.sv
tb/sv/tb.sv
